>>> hw/rtl/cycling_distance_cbrt_estimator_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef CYCLING_DISTANCE_CBRT_ESTIMATOR_UNIT_MACROS_SVH
`define CYCLING_DISTANCE_CBRT_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CDCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdce assertion failed");

// Next-cycle implication, off while reset is high.
`define CDCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdce assertion failed");

// Same-cycle implication that also holds through reset.
`define CDCE_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("cdce assertion failed");

`endif

>>> hw/rtl/cdce_pkg.sv
package cdce_pkg;

  localparam int INTENSITY_WIDTH = 16;
  localparam int MOTION_W        = 16;
  localparam int INT_USED_W      = (INTENSITY_WIDTH < MOTION_W) ? INTENSITY_WIDTH : MOTION_W;
  localparam int ROOT_W          = (INT_USED_W + 2) / 3;
  localparam int CUBE_W          = 3 * ROOT_W;

  localparam int MS_W    = 32;
  localparam int HR_W    = 8;
  localparam int GAIN_W  = 12;
  localparam int RATE_W  = 8;
  localparam int NUM_W   = GAIN_W + HR_W;
  localparam int ITERM_W = GAIN_W + ROOT_W;
  localparam int TERM_W  = (ITERM_W > NUM_W) ? ITERM_W : NUM_W;
  localparam int SPEED_W = TERM_W + 1;
  localparam int PROD_W  = SPEED_W + MS_W;
  localparam int DIST_W  = 32;

  localparam int MM_DIVISOR = 1000000;
  // One million is a power of two times an odd factor; shift off the power first.
  localparam int MM_SHIFT    = 6;
  localparam int MM_ODD      = MM_DIVISOR >> MM_SHIFT;
  localparam int ODD_W       = $clog2(MM_ODD);
  // Shifted products below the saturation point fit Y_W bits.
  localparam int Y_W         = DIST_W + ODD_W;
  localparam int RECIP_SHIFT = Y_W + ODD_W;
  localparam int RECIP_W     = RECIP_SHIFT - ODD_W + 1;
  localparam int FULL_W      = Y_W + RECIP_W;
  localparam int SPLIT_W     = Y_W / 2;
  localparam int Y_HI_W      = Y_W - SPLIT_W;
  localparam int R_HI_W      = RECIP_W - SPLIT_W;

  // Rounded-up reciprocal of the odd factor; exact for every input below 2^Y_W.
  localparam logic [RECIP_W-1:0] MM_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MM_ODD) - 64'd1) / 64'(MM_ODD));
  localparam logic [R_HI_W-1:0]  RECIP_HI = MM_RECIP[RECIP_W-1:SPLIT_W];
  localparam logic [SPLIT_W-1:0] RECIP_LO = MM_RECIP[SPLIT_W-1:0];
  // Products at or above this give a quotient past the output width.
  localparam logic [PROD_W-1:0]  SAT_PRODUCT =
    PROD_W'((64'd1 << DIST_W) * 64'(MM_DIVISOR));

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [GAIN_W-1:0] INTENSITY_GAIN_RESET = GAIN_W'(320);
  localparam logic [GAIN_W-1:0] EFFORT_GAIN_RESET    = GAIN_W'(850);
  localparam logic [RATE_W-1:0] RESTING_RATE_RESET   = RATE_W'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTENSITY_GAIN,
    REG_EFFORT_GAIN,
    REG_RESTING_RATE
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] intensity_gain;
    logic [GAIN_W-1:0] effort_gain;
    logic [RATE_W-1:0] resting_rate;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [MS_W-1:0]    elapsed_ms;
  } speed_item_t;

endpackage

>>> hw/rtl/cdce_ifs.sv
interface cdce_sample_if;
  import cdce_pkg::*;

  logic                valid;
  logic                ready;
  logic [MS_W-1:0]     elapsed_ms;
  logic [MOTION_W-1:0] motion_intensity;
  logic [HR_W-1:0]     heart_rate;

  modport source (output valid, elapsed_ms, motion_intensity, heart_rate, input ready);
  modport sink (input valid, elapsed_ms, motion_intensity, heart_rate, output ready);
endinterface

interface cdce_estimate_if;
  import cdce_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] travel_mm;
  logic              saturated;

  modport source (output valid, travel_mm, saturated, input ready);
  modport sink (input valid, travel_mm, saturated, output ready);
endinterface

>>> hw/rtl/cdce_speed.sv
module cdce_speed (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  cdce_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic [cdce_pkg::MS_W-1:0]     elapsed_ms,
  input  logic [cdce_pkg::MOTION_W-1:0] motion_intensity,
  input  logic [cdce_pkg::HR_W-1:0]     heart_rate,
  output logic                          out_valid,
  output cdce_pkg::speed_item_t         out_item
);
  import cdce_pkg::*;

  // Index 0 is the entry register; index k+1 follows division step k.
  logic                  v_s     [0:NUM_W];
  logic [NUM_W-1:0]      w_s     [0:NUM_W];
  logic [RATE_W-1:0]     rem_s   [0:NUM_W];
  logic [RATE_W-1:0]     rest_s  [0:NUM_W];
  logic [ROOT_W-1:0]     root_s  [0:NUM_W];
  logic [INT_USED_W-1:0] ints_s  [0:NUM_W];
  logic [MS_W-1:0]       ms_s    [0:NUM_W];
  logic [ITERM_W-1:0]    iterm_s [0:NUM_W];

  logic [RATE_W-1:0] rest_in;
  logic [HR_W-1:0]   hr_in;

  // A zero resting rate acts as one; an unknown heart rate takes the resting rate.
  assign rest_in = (cfg.resting_rate == '0) ? RATE_W'(1) : cfg.resting_rate;
  assign hr_in   = (heart_rate == '0) ? rest_in : heart_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (advance) begin
      v_s[0] <= in_valid;
    end
    if (advance) begin
      w_s[0]     <= NUM_W'(cfg.effort_gain) * NUM_W'(hr_in);
      rem_s[0]   <= '0;
      rest_s[0]  <= rest_in;
      root_s[0]  <= '0;
      ints_s[0]  <= motion_intensity[INT_USED_W-1:0];
      ms_s[0]    <= elapsed_ms;
      iterm_s[0] <= '0;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [RATE_W:0]    shifted;
    logic [RATE_W:0]    diff;
    logic               take;
    logic [ROOT_W-1:0]  root_nx;
    logic [ITERM_W-1:0] iterm_nx;

    // One restoring step of effort_gain * rate / rest.
    assign shifted = {rem_s[k], w_s[k][NUM_W-1]};
    assign diff    = shifted - {1'b0, rest_s[k]};
    assign take    = shifted >= {1'b0, rest_s[k]};

    if (k < ROOT_W) begin : g_root
      logic [ROOT_W-1:0]   trial;
      logic [2*ROOT_W-1:0] sq;
      logic [CUBE_W-1:0]   cube;

      // Keep the trial bit when its cube still fits under the intensity.
      assign trial   = root_s[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
      assign sq      = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
      assign cube    = CUBE_W'(sq) * CUBE_W'(trial);
      assign root_nx = (cube <= CUBE_W'(ints_s[k])) ? trial : root_s[k];
    end else begin : g_root_hold
      assign root_nx = root_s[k];
    end

    if (k == ROOT_W) begin : g_iterm
      assign iterm_nx = ITERM_W'(cfg.intensity_gain) * ITERM_W'(root_s[k]);
    end else begin : g_iterm_hold
      assign iterm_nx = iterm_s[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (advance) begin
        v_s[k+1] <= v_s[k];
      end
      if (advance) begin
        w_s[k+1]     <= {w_s[k][NUM_W-2:0], take};
        rem_s[k+1]   <= take ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
        rest_s[k+1]  <= rest_s[k];
        root_s[k+1]  <= root_nx;
        ints_s[k+1]  <= ints_s[k];
        ms_s[k+1]    <= ms_s[k];
        iterm_s[k+1] <= iterm_nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v_s[NUM_W];
    end
    if (advance) begin
      out_item.speed      <= SPEED_W'(iterm_s[NUM_W]) + SPEED_W'(w_s[NUM_W]);
      out_item.elapsed_ms <= ms_s[NUM_W];
    end
  end

endmodule

>>> hw/rtl/cdce_dist.sv
module cdce_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        in_valid,
  input  cdce_pkg::speed_item_t       in_item,
  output logic                        out_valid,
  output logic [cdce_pkg::DIST_W-1:0] travel_mm,
  output logic                        saturated
);
  import cdce_pkg::*;

  logic [PROD_W-1:0]          prod;
  logic                       v_m;
  logic                       over_m;
  logic [Y_W-1:0]             y_m;
  logic [Y_HI_W-1:0]          y_hi;
  logic [SPLIT_W-1:0]         y_lo;
  logic                       v_p;
  logic                       over_p;
  logic [Y_HI_W+R_HI_W-1:0]   pp_hh;
  logic [Y_HI_W+SPLIT_W-1:0]  pp_hl;
  logic [SPLIT_W+R_HI_W-1:0]  pp_lh;
  logic [2*SPLIT_W-1:0]       pp_ll;
  logic [FULL_W-1:0]          full;

  assign prod = PROD_W'(in_item.speed) * PROD_W'(in_item.elapsed_ms);

  // Flag saturation up front and drop the power-of-two part of the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (advance) begin
      v_m <= in_valid;
    end
    if (advance) begin
      over_m <= prod >= SAT_PRODUCT;
      y_m    <= prod[MM_SHIFT +: Y_W];
    end
  end

  assign y_hi = y_m[Y_W-1:SPLIT_W];
  assign y_lo = y_m[SPLIT_W-1:0];

  // Multiply by the reciprocal of the odd factor as four partial products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else if (advance) begin
      v_p <= v_m;
    end
    if (advance) begin
      over_p <= over_m;
      pp_hh  <= {{R_HI_W{1'b0}}, y_hi} * {{Y_HI_W{1'b0}}, RECIP_HI};
      pp_hl  <= {{SPLIT_W{1'b0}}, y_hi} * {{Y_HI_W{1'b0}}, RECIP_LO};
      pp_lh  <= {{R_HI_W{1'b0}}, y_lo} * {{SPLIT_W{1'b0}}, RECIP_HI};
      pp_ll  <= {{SPLIT_W{1'b0}}, y_lo} * {{SPLIT_W{1'b0}}, RECIP_LO};
    end
  end

  assign full = (FULL_W'(pp_hh) << (2 * SPLIT_W))
              + (FULL_W'(pp_hl) << SPLIT_W)
              + (FULL_W'(pp_lh) << SPLIT_W)
              + FULL_W'(pp_ll);

  // Clamp a quotient that does not fit the output width.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v_p;
    end
    if (advance) begin
      travel_mm <= over_p ? '1 : full[RECIP_SHIFT +: DIST_W];
      saturated <= over_p;
    end
  end

endmodule

>>> hw/rtl/cycling_distance_cbrt_estimator_unit.sv
// Cycling distance estimator.
// Each transfer on the sample channel (elapsed_ms, motion_intensity,
// heart_rate) yields exactly one transfer on the estimate channel
// (travel_mm, saturated), in order. Speed is intensity_gain times the
// floor cube root of the intensity plus effort_gain times heart rate over
// resting rate; distance is speed times elapsed_ms over one million.
// The pipeline takes one sample per cycle unless a result is stalled at the
// output, and has 25 register stages. Most of the depth is the restoring
// divider for the effort term, one quotient bit per stage (20 stages); the
// division by one million is a reciprocal multiply split over three stages.
// Configuration: cfg_write_en, cfg_index (0 intensity_gain, 1 effort_gain,
// 2 resting_rate) and cfg_data; write only while no sample is in flight.
// Reset (rst, synchronous) empties the pipeline and loads 320, 850 and 60.
// When the receiver holds estimate.ready low with a result waiting, the
// whole pipeline holds and sample.ready drops; nothing is lost or repeated.
module cycling_distance_cbrt_estimator_unit (
  input  logic                            clk,
  input  logic                            rst,
  cdce_sample_if.sink                     sample,
  cdce_estimate_if.source                 estimate,
  input  logic                            cfg_write_en,
  input  logic [cdce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cdce_pkg::*;

  cfg_t        cfg;
  logic        advance;
  logic        speed_valid;
  speed_item_t speed_item;

  // Advance all stages unless a finished result is stalled at the output.
  assign advance      = !estimate.valid || estimate.ready;
  assign sample.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{intensity_gain: INTENSITY_GAIN_RESET,
               effort_gain:    EFFORT_GAIN_RESET,
               resting_rate:   RESTING_RATE_RESET};
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_INTENSITY_GAIN: cfg.intensity_gain <= cfg_data[GAIN_W-1:0];
        REG_EFFORT_GAIN:    cfg.effort_gain    <= cfg_data[GAIN_W-1:0];
        REG_RESTING_RATE:   cfg.resting_rate   <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  cdce_speed u_speed (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .cfg              (cfg),
    .in_valid         (sample.valid),
    .elapsed_ms       (sample.elapsed_ms),
    .motion_intensity (sample.motion_intensity),
    .heart_rate       (sample.heart_rate),
    .out_valid        (speed_valid),
    .out_item         (speed_item)
  );

  cdce_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (speed_valid),
    .in_item     (speed_item),
    .out_valid   (estimate.valid),
    .travel_mm   (estimate.travel_mm),
    .saturated   (estimate.saturated)
  );

endmodule

>>> hw/rtl/cdce_checker.sv
`include "cycling_distance_cbrt_estimator_unit_macros.svh"

module cdce_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cdce_pkg::DIST_W-1:0] travel_mm,
  input logic                        saturated
);
  import cdce_pkg::*;

  // A stalled result holds its value.
  `CDCE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({travel_mm, saturated}))

  // A clamped result is all ones.
  `CDCE_ASSERT_IMPL(a_sat_max, clk, rst, out_valid && saturated, &travel_mm)

  // Input side stalls whenever the output stalls, and only then.
  `CDCE_ASSERT_IMPL(a_in_stall, clk, rst, in_valid || !in_valid, in_ready == (!out_valid || out_ready))

  // Reset empties the pipeline.
  `CDCE_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid)

endmodule

bind cycling_distance_cbrt_estimator_unit cdce_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (estimate.valid),
  .out_ready   (estimate.ready),
  .travel_mm   (estimate.travel_mm),
  .saturated   (estimate.saturated)
);

>>> verif/tb_cycling_distance_cbrt_estimator_unit.sv
module tb_cycling_distance_cbrt_estimator_unit;
  import cdce_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int SETTLE_CYCLES = 100;
  // Index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [MS_W-1:0]     elapsed_ms;
    logic [MOTION_W-1:0] motion_intensity;
    logic [HR_W-1:0]     heart_rate;
  } sample_t;

  typedef struct packed {
    logic [DIST_W-1:0] travel_mm;
    logic              saturated;
  } estimate_t;

  localparam sample_t CORNER_SAMPLES [12] = '{
    '{32'd0, 16'hFFFF, 8'hFF},
    '{32'd0, 16'd0, 8'd0},
    '{32'd1, 16'd0, 8'd0},
    '{32'hFFFF_FFFF, 16'hFFFF, 8'hFF},
    '{32'hFFFF_FFFF, 16'd0, 8'd0},
    '{32'd1000000, 16'd7, 8'd1},
    '{32'd1000000, 16'd8, 8'd0},
    '{32'd1000000, 16'd26, 8'd59},
    '{32'd1000000, 16'd27, 8'd61},
    '{32'd1000000, 16'd63999, 8'hFF},
    '{32'd1000000, 16'd64000, 8'd128},
    '{32'd12345, 16'd1, 8'd60}
  };

  class distance_scoreboard;
    cfg_t        settings;
    estimate_t   pending_estimates[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned saturations;
    int unsigned zero_intervals;
    int unsigned samples;

    function new();
      settings = '{INTENSITY_GAIN_RESET, EFFORT_GAIN_RESET, RESTING_RATE_RESET};
      mismatches = 0;
      checked = 0;
      saturations = 0;
      zero_intervals = 0;
      samples = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_INTENSITY_GAIN: settings.intensity_gain = data[GAIN_W-1:0];
        REG_EFFORT_GAIN:    settings.effort_gain = data[GAIN_W-1:0];
        REG_RESTING_RATE:   settings.resting_rate = data[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ROOT_W-1:0] intensity_root(logic [INT_USED_W-1:0] value);
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] trial;
      longint unsigned   cube;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        trial = root | (ROOT_W'(1) << b);
        cube = 64'(trial);
        cube = cube * cube * cube;
        if (cube <= 64'(value)) root = trial;
      end
      return root;
    endfunction

    function estimate_t estimate_distance(sample_t s);
      longint unsigned rest;
      longint unsigned rate;
      longint unsigned gain;
      longint unsigned speed;
      longint unsigned travel;
      estimate_t       e;
      e = '0;
      if (s.elapsed_ms == '0) return e;
      // A zero resting rate acts as one, both as divisor and as substitute.
      rest = (settings.resting_rate == '0) ? 64'd1 : 64'(settings.resting_rate);
      rate = (s.heart_rate == '0) ? rest : 64'(s.heart_rate);
      gain = 64'(settings.effort_gain);
      speed = 64'(settings.intensity_gain);
      speed = speed * 64'(intensity_root(s.motion_intensity[INT_USED_W-1:0]))
            + (gain * rate) / rest;
      travel = speed * 64'(s.elapsed_ms);
      travel = travel / 64'(MM_DIVISOR);
      if (travel > 64'hFFFF_FFFF) begin
        e.travel_mm = '1;
        e.saturated = 1'b1;
      end else begin
        e.travel_mm = travel[DIST_W-1:0];
      end
      return e;
    endfunction

    function void note_sample(sample_t s);
      samples++;
      if (s.elapsed_ms == '0) zero_intervals++;
      pending_estimates.push_back(estimate_distance(s));
    endfunction

    function void check_estimate(logic [DIST_W-1:0] travel_mm, logic saturated);
      estimate_t want;
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected estimate: distance %0d saturated %0b", travel_mm, saturated);
        return;
      end
      want = pending_estimates.pop_front();
      checked++;
      if (want.saturated) saturations++;
      if (travel_mm !== want.travel_mm || saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("estimate %0d: expected distance %0d saturated %0b, got distance %0d saturated %0b",
                   checked, want.travel_mm, want.saturated, travel_mm, saturated);
      end
    endfunction

    function int pending();
      return pending_estimates.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit sender_idling;
  bit receiver_idling;
  int pressure_request;
  int settings_applied;

  distance_scoreboard board;

  cdce_sample_if sample_ch();
  cdce_estimate_if estimate_ch();

  cycling_distance_cbrt_estimator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample_ch),
    .estimate     (estimate_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Receiver: check each transfer, then pick ready for the next edge.
  initial begin : estimate_receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    estimate_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && estimate_ch.valid === 1'b1 && estimate_ch.ready === 1'b1)
        board.check_estimate(estimate_ch.travel_mm, estimate_ch.saturated);
      if (pressure_request > 0) begin
        hold_left = pressure_request;
        pressure_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        estimate_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        estimate_ch.ready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        estimate_ch.ready <= 1'b0;
      end else begin
        estimate_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.apply_write(idx, data);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] intensity_gain,
                           input logic [CFG_DATA_W-1:0] effort_gain,
                           input logic [CFG_DATA_W-1:0] resting_rate);
    write_reg(REG_INTENSITY_GAIN, intensity_gain);
    write_reg(REG_EFFORT_GAIN, effort_gain);
    write_reg(REG_RESTING_RATE, resting_rate);
    settings_applied++;
  endtask

  task automatic configure_random();
    configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
  endtask

  // Hold valid across back-to-back transfers; drop it only for a gap.
  task automatic send_sample(input sample_t s);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.elapsed_ms <= s.elapsed_ms;
    sample_ch.motion_intensity <= s.motion_intensity;
    sample_ch.heart_rate <= s.heart_rate;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
    board.note_sample(s);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int      k;
    case ($urandom_range(0, 9))
      0:       s.elapsed_ms = '0;
      1, 2, 3: s.elapsed_ms = $urandom_range(1, 5000);
      4, 5, 6: s.elapsed_ms = $urandom;
      7:       s.elapsed_ms = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: s.elapsed_ms = $urandom_range(1, 1 << 20);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s.motion_intensity = MOTION_W'($urandom);
      4, 5, 6: begin
        // land on or next to a perfect cube
        k = $urandom_range(0, 40);
        s.motion_intensity = MOTION_W'(k * k * k + $urandom_range(0, 2) - 1);
      end
      7:       s.motion_intensity = '0;
      8:       s.motion_intensity = '1;
      default: s.motion_intensity = MOTION_W'($urandom_range(0, 300));
    endcase
    s.heart_rate = ($urandom_range(0, 5) == 0) ? HR_W'(0) : HR_W'($urandom);
    return s;
  endfunction

  task automatic send_corners();
    foreach (CORNER_SAMPLES[i]) send_sample(CORNER_SAMPLES[i]);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_sample(random_sample());
  endtask

  // Every sample gives one estimate, so an empty queue means the block is idle.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin : main_sequence
    board = new();
    sender_idling = 1'b1;
    receiver_idling = 1'b1;
    pressure_request = 0;
    settings_applied = 1;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = REG_INTENSITY_GAIN;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.elapsed_ms = '0;
    sample_ch.motion_intensity = '0;
    sample_ch.heart_rate = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values
    send_corners();
    send_random(60);
    drain();

    // largest gains, smallest divisor: saturation is common here
    configure(12'hFFF, 12'hFFF, 12'd1);
    send_corners();
    send_random(80);
    drain();

    configure(12'd0, 12'd0, 12'd255);
    send_random(40);
    drain();

    // zero resting rate behind set upper bits, plus a write past the list
    write_reg(REG_NONE, CFG_DATA_W'($urandom));
    configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 12'hF00);
    pressure_request = PRESSURE_CYCLES;
    send_random(80);
    drain();

    repeat (2) begin
      configure_random();
      send_random(90);
      drain();
    end

    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    configure_random();
    send_random(100);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d samples under %0d register settings, %0d estimates checked",
             board.samples, settings_applied, board.checked);
    $display("%0d saturated estimates, %0d zero-interval samples, %0d mismatches",
             board.saturations, board.zero_intervals, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
